// ----- design/spot_cone_bounding_sphere_macros.svh -----
// Assertion macros included by spot_cone_bounding_sphere.sv.
`ifndef SPOT_CONE_BOUNDING_SPHERE_MACROS_SVH
`define SPOT_CONE_BOUNDING_SPHERE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCBS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCBS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/scbs_pkg.sv -----
package scbs_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CORDIC_TABLE_LEN = 24;
	localparam int DIV_STEPS = 31;
	localparam int SQRT_STEPS = 15;

	localparam logic [14:0] PI_Q13 = 15'd25736;
	localparam logic [14:0] ONE_Q14 = 15'd16384;
	localparam logic [14:0] COS_QUARTER_PI_Q14 = 15'd11586;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	typedef struct packed {
		logic signed [31:0] tip_x;
		logic signed [31:0] tip_y;
		logic signed [31:0] tip_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [30:0] reach;
		logic [15:0] umbra_angle;
		logic [15:0] penumbra_angle;
	} light_t;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic [30:0] radius;
		logic [14:0] cos_inner;
		logic [14:0] cos_outer;
		logic [14:0] umbra_clamped;
		logic [14:0] penumbra_clamped;
	} sphere_t;

	typedef struct packed {
		logic signed [31:0] tip_x;
		logic signed [31:0] tip_y;
		logic signed [31:0] tip_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [30:0] reach;
		logic [14:0] um;
		logic [14:0] pe;
		logic [14:0] ci;
		logic [14:0] co;
	} side_t;

	function automatic logic signed [33:0] atan_q30(input int idx);
		case (idx)
			0: atan_q30 = 34'sd843314856;
			1: atan_q30 = 34'sd497837829;
			2: atan_q30 = 34'sd263043836;
			3: atan_q30 = 34'sd133525158;
			4: atan_q30 = 34'sd67021686;
			5: atan_q30 = 34'sd33543515;
			6: atan_q30 = 34'sd16775850;
			7: atan_q30 = 34'sd8388437;
			8: atan_q30 = 34'sd4194282;
			9: atan_q30 = 34'sd2097149;
			10: atan_q30 = 34'sd1048575;
			11: atan_q30 = 34'sd524287;
			12: atan_q30 = 34'sd262143;
			13: atan_q30 = 34'sd131071;
			14: atan_q30 = 34'sd65535;
			15: atan_q30 = 34'sd32767;
			16: atan_q30 = 34'sd16383;
			17: atan_q30 = 34'sd8191;
			18: atan_q30 = 34'sd4095;
			19: atan_q30 = 34'sd2047;
			20: atan_q30 = 34'sd1023;
			21: atan_q30 = 34'sd511;
			22: atan_q30 = 34'sd255;
			23: atan_q30 = 34'sd127;
			default: atan_q30 = 34'sd0;
		endcase
	endfunction

endpackage

// ----- design/scbs_cordic.sv -----
module scbs_cordic #(
	parameter int STEPS = scbs_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic en,
	input  logic [14:0] ang_inner,
	input  logic [14:0] ang_outer,
	output logic signed [33:0] x_inner,
	output logic signed [33:0] x_outer
);

	logic signed [33:0] x_s [1:STEPS][2];
	logic signed [33:0] y_s [1:STEPS][2];
	logic signed [33:0] z_s [1:STEPS][2];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [33:0] xp [2];
		logic signed [33:0] yp [2];
		logic signed [33:0] zp [2];

		if (i == 0) begin : g_first
			assign xp[0] = scbs_pkg::CORDIC_GAIN_Q30;
			assign xp[1] = scbs_pkg::CORDIC_GAIN_Q30;
			assign yp[0] = '0;
			assign yp[1] = '0;
			assign zp[0] = $signed({3'b000, ang_inner, 16'h0000});
			assign zp[1] = $signed({3'b000, ang_outer, 16'h0000});
		end else begin : g_next
			assign xp = x_s[i];
			assign yp = y_s[i];
			assign zp = z_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 2; j++) begin
					if (zp[j] >= 0) begin
						x_s[i+1][j] <= xp[j] - (yp[j] >>> i);
						y_s[i+1][j] <= yp[j] + (xp[j] >>> i);
						z_s[i+1][j] <= zp[j] - scbs_pkg::atan_q30(i);
					end else begin
						x_s[i+1][j] <= xp[j] + (yp[j] >>> i);
						y_s[i+1][j] <= yp[j] - (xp[j] >>> i);
						z_s[i+1][j] <= zp[j] + scbs_pkg::atan_q30(i);
					end
				end
			end
		end
	end

	assign x_inner = x_s[STEPS][0];
	assign x_outer = x_s[STEPS][1];

endmodule

// ----- design/scbs_divsqrt.sv -----
module scbs_divsqrt (
	input  logic clk,
	input  logic en,
	input  logic [44:0] num,
	input  logic [14:0] den,
	input  logic [28:0] rad_sq,
	output logic [30:0] quo,
	output logic [14:0] root
);

	localparam int N = scbs_pkg::DIV_STEPS;

	logic [15:0] rem_s [1:N];
	logic [30:0] low_s [1:N];
	logic [30:0] quo_s [1:N];
	logic [14:0] den_s [1:N];
	logic [17:0] srem_s [1:N];
	logic [29:0] sv_s [1:N];
	logic [14:0] sq_s [1:N];

	for (genvar i = 0; i < N; i++) begin : g_step
		logic [15:0] remp;
		logic [30:0] lowp;
		logic [30:0] quop;
		logic [14:0] denp;
		logic [17:0] sremp;
		logic [29:0] svp;
		logic [14:0] sqp;
		logic [15:0] r2;
		logic [17:0] t_rem;
		logic [17:0] trial;

		if (i == 0) begin : g_first
			assign remp = {2'b00, num[44:31]};
			assign lowp = num[30:0];
			assign quop = '0;
			assign denp = den;
			assign sremp = '0;
			assign svp = {1'b0, rad_sq};
			assign sqp = '0;
		end else begin : g_next
			assign remp = rem_s[i];
			assign lowp = low_s[i];
			assign quop = quo_s[i];
			assign denp = den_s[i];
			assign sremp = srem_s[i];
			assign svp = sv_s[i];
			assign sqp = sq_s[i];
		end

		assign r2 = {remp[14:0], lowp[30]};
		assign t_rem = {sremp[15:0], svp[29:28]};
		assign trial = {1'b0, sqp, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i+1] <= denp;
				low_s[i+1] <= {lowp[29:0], 1'b0};
				if (r2 >= {1'b0, denp}) begin
					rem_s[i+1] <= r2 - {1'b0, denp};
					quo_s[i+1] <= {quop[29:0], 1'b1};
				end else begin
					rem_s[i+1] <= r2;
					quo_s[i+1] <= {quop[29:0], 1'b0};
				end
				sv_s[i+1] <= {svp[27:0], 2'b00};
				if (i < scbs_pkg::SQRT_STEPS) begin
					if (t_rem >= trial) begin
						srem_s[i+1] <= t_rem - trial;
						sq_s[i+1] <= {sqp[13:0], 1'b1};
					end else begin
						srem_s[i+1] <= t_rem;
						sq_s[i+1] <= {sqp[13:0], 1'b0};
					end
				end else if (i == scbs_pkg::SQRT_STEPS) begin
					srem_s[i+1] <= sremp;
					sq_s[i+1] <= sqp + 15'(sremp > {3'b000, sqp});
				end else begin
					srem_s[i+1] <= sremp;
					sq_s[i+1] <= sqp;
				end
			end
		end
	end

	assign quo = quo_s[N];
	assign root = sq_s[N];

endmodule

// ----- design/spot_cone_bounding_sphere.sv -----
// Channel   Signals                        Direction  Beat
// light     light_valid, light_stall       in         one spot light (light_t)
// sphere    sphere_valid, sphere_stall     out        one bounding sphere (sphere_t)
//
// One beat enters per cycle while light_stall is low; a result passes through the
// CORDIC pipeline and the 31-stage radix-2 divider that also carries the root.
// Reset clears only the valid bits, the skid register's included.
// A stalled result moves into the skid register; light_stall then rises and
// the whole pipeline holds until that beat is taken.
module spot_cone_bounding_sphere #(
	parameter int CORDIC_STEPS = scbs_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic light_valid,
	output logic light_stall,
	input  scbs_pkg::light_t light,
	output logic sphere_valid,
	input  logic sphere_stall,
	output scbs_pkg::sphere_t sphere
);

	`include "spot_cone_bounding_sphere_macros.svh"

	localparam int K_COS = CORDIC_STEPS + 1;
	localparam int K_PREP = CORDIC_STEPS + 2;
	localparam int K_DIV = K_PREP + scbs_pkg::DIV_STEPS;
	localparam int K_M1 = K_DIV + 1;
	localparam int K_M2 = K_DIV + 2;
	localparam int K_M3 = K_DIV + 3;
	localparam int K_OUT = K_DIV + 4;
	localparam int NST = K_OUT + 1;

	function automatic logic signed [31:0] place(input logic signed [31:0] tip,
			input logic signed [47:0] prod);
		logic signed [48:0] rnd;
		logic signed [35:0] total;
		rnd = {prod[47], prod} + 49'sd8192;
		total = {{4{tip[31]}}, tip} + {rnd[48], rnd[48:14]};
		if (total > 36'sd2147483647) begin
			place = 32'sh7FFFFFFF;
		end else if (total < -36'sd2147483648) begin
			place = 32'sh80000000;
		end else begin
			place = total[31:0];
		end
	endfunction

	logic en;
	logic [NST-1:0] valid_q;
	logic skid_valid_q;
	scbs_pkg::sphere_t skid_q;
	scbs_pkg::sphere_t out_s;
	scbs_pkg::side_t side_s [NST];

	logic signed [33:0] x_inner;
	logic signed [33:0] x_outer;
	logic [14:0] ci_w;
	logic [14:0] co_w;
	logic [44:0] num_s;
	logic [28:0] rad_sq_s;
	logic [30:0] quo;
	logic [14:0] root;
	logic [45:0] pd_s;
	logic [45:0] pr_s;
	logic [30:0] quo_m1_s;
	logic big_s;
	logic [30:0] dist_s;
	logic [30:0] rad_m2_s;
	logic [30:0] rad_m3_s;
	logic signed [47:0] px_s;
	logic signed [47:0] py_s;
	logic signed [47:0] pz_s;
	logic [32:0] pr_rnd;

	assign en = !skid_valid_q;
	assign light_stall = skid_valid_q;
	assign sphere_valid = skid_valid_q || valid_q[K_OUT];
	assign sphere = skid_valid_q ? skid_q : out_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			skid_valid_q <= 1'b0;
		end else begin
			if (en) begin
				valid_q <= {valid_q[NST-2:0], light_valid};
			end
			if (en && valid_q[K_OUT] && sphere_stall) begin
				skid_valid_q <= 1'b1;
			end else if (skid_valid_q && !sphere_stall) begin
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_q[K_OUT] && sphere_stall) begin
			skid_q <= out_s;
		end
	end

	function automatic logic [14:0] cos_round(input logic signed [33:0] x);
		logic signed [33:0] r;
		r = (x + 34'sd32768) >>> 16;
		if (r < 0) begin
			cos_round = '0;
		end else if (r > $signed({19'd0, scbs_pkg::ONE_Q14})) begin
			cos_round = scbs_pkg::ONE_Q14;
		end else begin
			cos_round = r[14:0];
		end
	endfunction

	assign ci_w = cos_round(x_inner);
	assign co_w = cos_round(x_outer);

	for (genvar k = 0; k < NST; k++) begin : g_side
		if (k == 0) begin : g_clamp
			always_ff @(posedge clk) begin
				logic [14:0] um;
				if (en) begin
					um = (light.umbra_angle > {1'b0, scbs_pkg::PI_Q13}) ?
						scbs_pkg::PI_Q13 : light.umbra_angle[14:0];
					side_s[0].tip_x <= light.tip_x;
					side_s[0].tip_y <= light.tip_y;
					side_s[0].tip_z <= light.tip_z;
					side_s[0].dir_x <= light.dir_x;
					side_s[0].dir_y <= light.dir_y;
					side_s[0].dir_z <= light.dir_z;
					side_s[0].reach <= light.reach;
					side_s[0].um <= um;
					if (light.penumbra_angle < {1'b0, um}) begin
						side_s[0].pe <= um;
					end else if (light.penumbra_angle > {1'b0, scbs_pkg::PI_Q13}) begin
						side_s[0].pe <= scbs_pkg::PI_Q13;
					end else begin
						side_s[0].pe <= light.penumbra_angle[14:0];
					end
					side_s[0].ci <= '0;
					side_s[0].co <= '0;
				end
			end
		end else if (k == K_COS) begin : g_cos
			always_ff @(posedge clk) begin
				scbs_pkg::side_t nxt;
				if (en) begin
					nxt = side_s[k-1];
					nxt.ci = ci_w;
					nxt.co = co_w;
					side_s[k] <= nxt;
				end
			end
		end else begin : g_copy
			always_ff @(posedge clk) begin
				if (en) begin
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	scbs_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk(clk),
		.en(en),
		.ang_inner(side_s[0].um),
		.ang_outer(side_s[0].pe),
		.x_inner(x_inner),
		.x_outer(x_outer)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s <= {1'b0, side_s[K_COS].reach, 13'd0} + {31'd0, side_s[K_COS].co[14:1]};
			rad_sq_s <= 29'h1000_0000 - 29'({15'd0, side_s[K_COS].co} * {15'd0, side_s[K_COS].co});
		end
	end

	scbs_divsqrt u_divsqrt (
		.clk(clk),
		.en(en),
		.num(num_s),
		.den(side_s[K_PREP].co),
		.rad_sq(rad_sq_s),
		.quo(quo),
		.root(root)
	);

	assign pr_rnd = pr_s[46-1:14] + 33'(pr_s[13]);

	always_ff @(posedge clk) begin
		if (en) begin
			pd_s <= {31'd0, side_s[K_DIV].co} * {15'd0, side_s[K_DIV].reach};
			pr_s <= {31'd0, root} * {15'd0, side_s[K_DIV].reach};
			quo_m1_s <= quo;
			big_s <= side_s[K_DIV].co >= scbs_pkg::COS_QUARTER_PI_Q14;

			if (big_s) begin
				dist_s <= quo_m1_s;
				rad_m2_s <= quo_m1_s;
			end else begin
				dist_s <= 31'((pd_s + 46'd8192) >> 14);
				rad_m2_s <= (pr_rnd > 33'h07FFFFFFF) ? 31'h7FFFFFFF : pr_rnd[30:0];
			end

			px_s <= $signed({1'b0, dist_s}) * side_s[K_M2].dir_x;
			py_s <= $signed({1'b0, dist_s}) * side_s[K_M2].dir_y;
			pz_s <= $signed({1'b0, dist_s}) * side_s[K_M2].dir_z;
			rad_m3_s <= rad_m2_s;

			out_s.center_x <= place(side_s[K_M3].tip_x, px_s);
			out_s.center_y <= place(side_s[K_M3].tip_y, py_s);
			out_s.center_z <= place(side_s[K_M3].tip_z, pz_s);
			out_s.radius <= rad_m3_s;
			out_s.cos_inner <= side_s[K_M3].ci;
			out_s.cos_outer <= side_s[K_M3].co;
			out_s.umbra_clamped <= side_s[K_M3].um;
			out_s.penumbra_clamped <= side_s[K_M3].pe;
		end
	end

	`SCBS_ASSERT_NXT(a_held, sphere_valid && sphere_stall, sphere_valid,
		"stalled result beat was dropped")
	`SCBS_ASSERT_IMP(a_order, sphere_valid,
		sphere.umbra_clamped <= sphere.penumbra_clamped,
		"penumbra below umbra after clamping")
	`SCBS_ASSERT_IMP(a_skid, $rose(skid_valid_q), $past(sphere_stall),
		"skid register filled without a stall")

endmodule
